[sv/tsort_pkg.sv]
// ----------------------------------------------------------------------------
// Topological sort package
// Shared widths, sizes and the item-queue record.
// ----------------------------------------------------------------------------
package tsort_pkg;
    localparam int MaxNodes = 64;
    localparam int IdW      = 6;
    localparam int CntW     = 7;
    localparam int QDepth   = 4;
    localparam int QAw      = 2;

    typedef struct packed {
        logic           fin;
        logic [IdW-1:0] from_id;
        logic [IdW-1:0] to_id;
    } t_item;
endpackage

[sv/topological_sort_with_cycle_break_core.sv]
// ----------------------------------------------------------------------------
// Topological sort with cycle break
// Loads node pairs and emits a topological order, breaking cycles.
// ----------------------------------------------------------------------------
// Input queue: push/full with i_mode, i_from_node, i_to_node. Mode 0 loads a
// pair, mode 1 emits the ordering of all registered nodes.
// Result queue: empty/pop with o_node_id, o_cycle_break, o_last; o_last marks
// the final node. A finish with no nodes gives no beats.
// A four-entry queue parts the loader from the sequencer, so pairs are taken
// while the sequencer works. For a pair, the sequencer first registers
// from_node and reads the edge row and predecessor count of to_node, then
// registers to_node and records the edge.
// Each emitted node costs a scan of the registration order, with predecessor
// reads for a live node, plus, when no free node exists, a depth-first search
// over the predecessor edges with its pushes and pops. The sequencer holds
// while a result beat waits for pop.
// After reset and after each finish a clearing pass runs over the per-node
// tables; pushed beats queue meanwhile.
// ----------------------------------------------------------------------------
module topological_sort_with_cycle_break_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_mode,
    input  logic [5:0] i_from_node,
    input  logic [5:0] i_to_node,
    output logic       empty,
    input  logic       pop,
    output logic [5:0] o_node_id,
    output logic       o_cycle_break,
    output logic       o_last
);
    import tsort_pkg::*;

    t_item w_in, w_q;
    logic  w_avail, w_take, w_valid;

    assign w_in = '{fin: i_mode, from_id: i_from_node, to_id: i_to_node};

    tsort_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item(w_in), .o_full(full),
        .i_take(w_take), .o_avail(w_avail), .o_item(w_q)
    );

    tsort_back u_back (
        .i_clk, .i_rst_n, .i_avail(w_avail), .i_item(w_q), .o_take(w_take),
        .o_valid(w_valid), .o_node_id, .o_cycle_break, .o_last, .i_pop(pop)
    );

    assign empty = !w_valid;

    a_take_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_avail) else $error("take without item");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_node_id))
        else $error("result changed while stalled");
endmodule

[sv/tsort_front.sv]
// ----------------------------------------------------------------------------
// Topological sort front end
// Accepts beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tsort_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tsort_pkg::t_item     i_item,
    output logic                 o_full,
    input  logic                 i_take,
    output logic                 o_avail,
    output tsort_pkg::t_item     o_item
);
    import tsort_pkg::*;

    t_item             r_mem [QDepth];
    logic [QAw-1:0]    r_wp, r_rp;
    logic [QAw:0]      r_cnt;
    logic              w_wr, w_rd;

    assign o_full  = (r_cnt == QAw'(0) + (QAw+1)'(QDepth));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAw+1)'(w_wr) - (QAw+1)'(w_rd);
        end
    end
endmodule

[sv/tsort_back.sv]
// ----------------------------------------------------------------------------
// Topological sort back end
// Graph store, repeated scan and depth-first cycle search sequencer.
// ----------------------------------------------------------------------------
module tsort_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  tsort_pkg::t_item     i_item,
    output logic                 o_take,
    output logic                 o_valid,
    output logic [5:0]           o_node_id,
    output logic                 o_cycle_break,
    output logic                 o_last,
    input  logic                 i_pop
);
    import tsort_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LB, S_SCAN, S_SORD, S_PCHK, S_PRD, S_SINIT, S_SRCH, S_SPOP,
        S_SCHK, S_SPSH, S_EMIT, S_WAIT, S_CLR
    } t_state;

    t_state              r_st;
    logic [IdW-1:0]      r_order [MaxNodes];
    logic [IdW-1:0]      r_ord_rd;
    logic [CntW-1:0]     r_total;
    logic [MaxNodes-1:0] r_known, r_live, r_vis;
    logic [MaxNodes-1:0] r_ebits [MaxNodes];
    logic [MaxNodes-1:0] r_erow;
    logic [CntW-1:0]     r_ptot [MaxNodes];
    logic [CntW-1:0]     r_pt_rd;
    logic [IdW-1:0]      r_pmem [MaxNodes*MaxNodes];
    logic [IdW-1:0]      r_prd;
    logic [CntW+IdW-1:0] r_stack [MaxNodes];
    logic [CntW+IdW-1:0] r_sk_rd;
    logic [CntW-1:0]     r_dep, r_pos, r_k, r_emitted, r_tk;
    logic [IdW-1:0]      r_cur, r_first, r_chosen, r_tn;
    logic                r_any, r_brk, r_oka;

    logic [IdW-1:0]      w_a, w_b;
    logic                w_kna, w_oka, w_knb, w_okb, w_newb, w_edge, w_push;
    logic [CntW-1:0]     w_tk1;
    logic                w_ord_we, w_pt_re, w_pm_re;
    logic [IdW-1:0]      w_pt_ra;
    logic [2*IdW-1:0]    w_pm_ra;

    assign w_a    = i_item.from_id;
    assign w_b    = i_item.to_id;
    assign w_kna  = r_known[w_a];
    assign w_oka  = w_kna || (r_total < CntW'(MaxNodes));
    assign w_knb  = r_known[w_b];
    assign w_okb  = w_knb || (r_total < CntW'(MaxNodes));
    assign w_newb = !w_knb && w_okb;
    assign w_edge = r_oka && w_okb && (w_a != w_b) && !r_erow[w_a];
    assign w_push = (r_st == S_SCHK) && !r_vis[r_prd] && r_live[r_prd]
                    && (r_dep < CntW'(MaxNodes));
    assign w_tk1  = r_tk - 1'b1;

    assign w_ord_we = ((r_st == S_IDLE) && i_avail && !i_item.fin && !w_kna && w_oka)
                      || ((r_st == S_LB) && w_newb);

    assign o_take  = ((r_st == S_IDLE) && i_avail && i_item.fin) || (r_st == S_LB);
    assign o_valid = (r_st == S_WAIT);

    always_comb begin
        w_pt_re = 1'b1;
        case (r_st)
            S_IDLE:  w_pt_ra = w_b;
            S_SCAN:  w_pt_ra = r_first;
            S_SORD:  w_pt_ra = r_ord_rd;
            S_SCHK:  w_pt_ra = r_prd;
            default: begin
                w_pt_ra = r_cur;
                w_pt_re = 1'b0;
            end
        endcase
    end

    assign w_pm_re = (r_st == S_PCHK) || (r_st == S_SRCH);
    assign w_pm_ra = (r_st == S_SRCH) ? {r_tn, w_tk1[IdW-1:0]} : {r_cur, r_k[IdW-1:0]};

    // registration order
    always_ff @(posedge i_clk) begin
        if (w_ord_we) begin
            r_order[r_total[IdW-1:0]] <= (r_st == S_LB) ? w_b : w_a;
        end
        if (r_st == S_SCAN) begin
            r_ord_rd <= r_order[r_pos[IdW-1:0]];
        end
    end

    // predecessor bit rows
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            r_ebits[r_pos[IdW-1:0]] <= '0;
        end else if (r_st == S_LB && w_edge) begin
            r_ebits[w_b] <= r_erow | (MaxNodes'(1) << w_a);
        end
        if (r_st == S_IDLE) begin
            r_erow <= r_ebits[w_b];
        end
    end

    // predecessor counts
    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            r_ptot[r_pos[IdW-1:0]] <= '0;
        end else if (r_st == S_LB && w_edge) begin
            r_ptot[w_b] <= r_pt_rd + 1'b1;
        end
        if (w_pt_re) begin
            r_pt_rd <= r_ptot[w_pt_ra];
        end
    end

    // predecessor lists
    always_ff @(posedge i_clk) begin
        if (r_st == S_LB && w_edge) begin
            r_pmem[{w_b, r_pt_rd[IdW-1:0]}] <= w_a;
        end
        if (w_pm_re) begin
            r_prd <= r_pmem[w_pm_ra];
        end
    end

    // search stack below the cached top entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_dep[IdW-1:0] - IdW'(1)] <= {r_tk, r_tn};
        end
        if (r_st == S_SRCH) begin
            r_sk_rd <= r_stack[r_dep[IdW-1:0] - IdW'(2)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_pos   <= '0;
            r_total <= '0;
            r_known <= '0;
            r_live  <= '0;
            r_vis   <= '0;
        end else begin
            case (r_st)
                S_CLR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == CntW'(MaxNodes-1)) begin
                        r_st <= S_IDLE;
                        r_total <= '0;
                        r_known <= '0;
                        r_live  <= '0;
                        r_vis   <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_avail) begin
                        if (i_item.fin) begin
                            r_pos <= '0; r_any <= 1'b0; r_emitted <= '0;
                            r_st <= S_SCAN;
                        end else begin
                            if (!w_kna && w_oka) begin
                                r_known[w_a] <= 1'b1; r_live[w_a] <= 1'b1;
                                r_total <= r_total + 1'b1;
                            end
                            r_oka <= w_oka;
                            r_st <= S_LB;
                        end
                    end
                end
                S_LB: begin
                    if (w_newb) begin
                        r_known[w_b] <= 1'b1; r_live[w_b] <= 1'b1;
                        r_total <= r_total + 1'b1;
                    end
                    r_st <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_pos == r_total) begin
                        if (!r_any) begin
                            r_pos <= '0; r_st <= S_CLR;
                        end else begin
                            r_brk <= 1'b1;
                            r_st <= S_SINIT;
                        end
                    end else begin
                        r_st <= S_SORD;
                    end
                end
                S_SORD: begin
                    if (r_live[r_ord_rd]) begin
                        r_cur <= r_ord_rd;
                        if (!r_any) r_first <= r_ord_rd;
                        r_any <= 1'b1;
                        r_k <= '0;
                        r_st <= S_PCHK;
                    end else begin
                        r_pos <= r_pos + 1'b1; r_st <= S_SCAN;
                    end
                end
                S_PCHK: begin
                    if (r_k == r_pt_rd) begin
                        r_chosen <= r_cur; r_brk <= 1'b0; r_st <= S_EMIT;
                    end else begin
                        r_st <= S_PRD;
                    end
                end
                S_PRD: begin
                    if (r_live[r_prd]) begin
                        r_pos <= r_pos + 1'b1; r_st <= S_SCAN;
                    end else begin
                        r_k <= r_k + 1'b1; r_st <= S_PCHK;
                    end
                end
                S_SINIT: begin
                    r_vis[r_first] <= 1'b1;
                    r_tn <= r_first;
                    r_tk <= r_pt_rd;
                    r_dep <= CntW'(1);
                    r_st <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_dep == '0) begin
                        r_chosen <= r_first; r_st <= S_EMIT;
                    end else if (r_tk == '0) begin
                        r_dep <= r_dep - 1'b1;
                        if (r_dep != CntW'(1)) r_st <= S_SPOP;
                    end else begin
                        r_tk <= w_tk1;
                        r_st <= S_SCHK;
                    end
                end
                S_SPOP: begin
                    r_tk <= r_sk_rd[CntW+IdW-1:IdW];
                    r_tn <= r_sk_rd[IdW-1:0];
                    r_st <= S_SRCH;
                end
                S_SCHK: begin
                    if (r_vis[r_prd]) begin
                        r_chosen <= r_prd; r_st <= S_EMIT;
                    end else if (r_live[r_prd]) begin
                        if (!w_push) begin
                            r_chosen <= r_first; r_st <= S_EMIT;
                        end else begin
                            r_vis[r_prd] <= 1'b1;
                            r_tn <= r_prd;
                            r_st <= S_SPSH;
                        end
                    end else begin
                        r_st <= S_SRCH;
                    end
                end
                S_SPSH: begin
                    r_tk <= r_pt_rd;
                    r_dep <= r_dep + 1'b1;
                    r_st <= S_SRCH;
                end
                S_EMIT: begin
                    r_vis <= '0;
                    r_live[r_chosen] <= 1'b0;
                    r_emitted <= r_emitted + 1'b1;
                    o_node_id <= r_chosen;
                    o_cycle_break <= r_brk;
                    o_last <= (r_emitted + 1'b1 == r_total);
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_pop) begin
                        r_pos <= '0; r_any <= 1'b0; r_st <= S_SCAN;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[dv/topological_sort_with_cycle_break_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Topological sort with cycle break: testbench
// Drives loads of node pairs and finish beats, predicts each emitted order
// with a behavioural model of the sort and compares every result beat.
// ----------------------------------------------------------------------------
module topological_sort_with_cycle_break_core_test;
    import tsort_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam logic [1:0] NODE_DEAD    = 2'd0;
    localparam logic [1:0] NODE_LIVE    = 2'd1;
    localparam logic [1:0] NODE_VISITED = 2'd2;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [5:0] node_id;
        logic       cycle_break;
        logic       last;
    } t_emit;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_mode = 1'b0;
    logic [5:0] i_from_node = '0;
    logic [5:0] i_to_node = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [5:0] o_node_id;
    logic       o_cycle_break;
    logic       o_last;

    t_emit      emit_queue[$];
    int         mismatches = 0;
    int         cycles = 0;
    logic       running = 1'b0;

    // sort model state
    logic [5:0]  reg_order[MaxNodes];
    int          reg_total;
    logic        is_known[64];
    logic [1:0]  status[64];
    logic [63:0] pred_mask[64];
    logic [5:0]  pred_list[64][64];
    int          pred_count[64];

    topological_sort_with_cycle_break_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("topological_sort_with_cycle_break_core_test: errors");
            $finish;
        end
    end

    function automatic void clear_model();
        reg_total = 0;
        for (int i = 0; i < 64; i++) begin
            is_known[i] = 1'b0;
            status[i] = NODE_DEAD;
            pred_mask[i] = '0;
            pred_count[i] = 0;
        end
    endfunction

    function automatic logic enrol_node(logic [5:0] id);
        if (is_known[id]) return 1'b1;
        if (reg_total >= MaxNodes) return 1'b0;
        is_known[id] = 1'b1;
        status[id] = NODE_LIVE;
        reg_order[reg_total] = id;
        reg_total++;
        return 1'b1;
    endfunction

    function automatic logic has_live_pred(logic [5:0] id);
        for (int k = 0; k < pred_count[id]; k++)
            if (status[pred_list[id][k]] == NODE_LIVE) return 1'b1;
        return 1'b0;
    endfunction

    // depth-first over predecessors, newest first; -1 when nothing found
    function automatic int find_cycle_node(logic [5:0] start);
        logic [5:0] stk_node[64];
        int         stk_next[64];
        int         depth;
        logic [5:0] n;
        logic [5:0] p;
        if (status[start] != NODE_LIVE)
            return status[start] == NODE_VISITED ? int'(start) : -1;
        depth = 0;
        status[start] = NODE_VISITED;
        stk_node[0] = start;
        stk_next[0] = pred_count[start];
        depth = 1;
        while (depth > 0) begin
            n = stk_node[depth-1];
            if (stk_next[depth-1] == 0) begin
                depth--;
            end else begin
                stk_next[depth-1]--;
                p = pred_list[n][stk_next[depth-1]];
                if (status[p] == NODE_VISITED) return int'(p);
                if (status[p] == NODE_LIVE) begin
                    if (depth >= 64) return -1;
                    status[p] = NODE_VISITED;
                    stk_node[depth] = p;
                    stk_next[depth] = pred_count[p];
                    depth++;
                end
            end
        end
        return -1;
    endfunction

    function automatic void predict_beat(logic mode, logic [5:0] a, logic [5:0] b);
        logic ok_a, ok_b, any_live, found, broke;
        logic [5:0] chosen, first_live, id;
        int r, start_idx;
        if (mode == MODE_LOAD) begin
            ok_a = enrol_node(a);
            ok_b = enrol_node(b);
            if (ok_a && ok_b && a != b && !pred_mask[b][a]) begin
                pred_mask[b][a] = 1'b1;
                pred_list[b][pred_count[b]] = a;
                pred_count[b]++;
            end
            return;
        end
        start_idx = emit_queue.size();
        forever begin
            any_live = 1'b0;
            found = 1'b0;
            broke = 1'b0;
            chosen = '0;
            first_live = '0;
            for (int pos = 0; pos < reg_total && !found; pos++) begin
                id = reg_order[pos];
                if (status[id] == NODE_LIVE) begin
                    if (!any_live) first_live = id;
                    any_live = 1'b1;
                    if (!has_live_pred(id)) begin
                        chosen = id;
                        found = 1'b1;
                    end
                end
            end
            if (!any_live) break;
            if (!found) begin
                r = find_cycle_node(first_live);
                chosen = r < 0 ? first_live : r[5:0];
                broke = 1'b1;
                for (int j = 0; j < 64; j++)
                    if (status[j] == NODE_VISITED) status[j] = NODE_LIVE;
            end
            status[chosen] = NODE_DEAD;
            emit_queue.push_back('{chosen, broke, 1'b0});
        end
        if (emit_queue.size() > start_idx) emit_queue[$].last = 1'b1;
        clear_model();
    endfunction

    // result side: compare at negedge, outputs are stable until the next edge
    always @(negedge i_clk) begin
        t_emit want;
        if (running && pop && !empty) begin
            if (emit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: node %0d brk %0b last %0b",
                             o_node_id, o_cycle_break, o_last);
            end else begin
                want = emit_queue.pop_front();
                if (o_node_id !== want.node_id || o_cycle_break !== want.cycle_break ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp node %0d brk %0b last %0b, got %0d %0b %0b",
                                 want.node_id, want.cycle_break, want.last,
                                 o_node_id, o_cycle_break, o_last);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < 4) begin
            stall_left <= $urandom_range(10, 60);
            pop <= 1'b0;
        end else begin
            pop <= $urandom_range(0, 3) != 0;
        end
    end

    logic quiet = 1'b0;

    task automatic send_beat(logic mode, logic [5:0] a, logic [5:0] b);
        int gap;
        gap = quiet ? 0 : ($urandom_range(0, 19) == 0 ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2));
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= mode;
        i_from_node <= a;
        i_to_node <= b;
        forever begin
            @(negedge i_clk);
            if (!full) break;
        end
        @(posedge i_clk);
        predict_beat(mode, a, b);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (emit_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_beat(MODE_FINISH, 6'd63, 6'd63);            // finish with nothing loaded
        send_beat(MODE_LOAD, 6'd0, 6'd63);
        send_beat(MODE_LOAD, 6'd63, 6'd42);
        send_beat(MODE_LOAD, 6'd0, 6'd63);               // repeated pair
        send_beat(MODE_LOAD, 6'd21, 6'd21);              // register only
        send_beat(MODE_FINISH, 6'd0, 6'd0);
        send_beat(MODE_LOAD, 6'd5, 6'd6);                // three-node cycle plus tail
        send_beat(MODE_LOAD, 6'd6, 6'd7);
        send_beat(MODE_LOAD, 6'd7, 6'd5);
        send_beat(MODE_LOAD, 6'd7, 6'd9);
        send_beat(MODE_LOAD, 6'd9, 6'd9);
        send_beat(MODE_FINISH, 6'd42, 6'd21);
        send_beat(MODE_LOAD, 6'd1, 6'd2);                // two loops sharing a node
        send_beat(MODE_LOAD, 6'd2, 6'd1);
        send_beat(MODE_LOAD, 6'd2, 6'd3);
        send_beat(MODE_LOAD, 6'd3, 6'd2);
        send_beat(MODE_FINISH, 6'd0, 6'd0);
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 63; i++)
            send_beat(MODE_LOAD, 6'(i), 6'(i + 1));
        send_beat(MODE_LOAD, 6'd63, 6'd0);
        send_beat(MODE_LOAD, 6'd10, 6'd50);
        send_beat(MODE_FINISH, 6'd0, 6'd0);
        drain();
    endtask

    task automatic test_random();
        int sent, n, span;
        logic [5:0] a, b, base;
        sent = 0;
        while (sent < 195) begin
            span = $urandom_range(0, 5) == 0 ? 63 : $urandom_range(1, 12);
            base = 6'($urandom_range(0, 63 - span));
            n = $urandom_range(0, 12);
            quiet = $urandom_range(0, 4) == 0;
            for (int i = 0; i < n; i++) begin
                a = 6'(base + $urandom_range(0, span));
                b = $urandom_range(0, 7) == 0 ? a : 6'(base + $urandom_range(0, span));
                send_beat(MODE_LOAD, a, b);
                sent++;
            end
            send_beat(MODE_FINISH, 6'($urandom), 6'($urandom));
            sent++;
            if ($urandom_range(0, 9) == 0) begin
                push <= 1'b0;
                while (emit_queue.size() != 0) @(posedge i_clk);
            end
        end
        quiet = 1'b0;
        drain();
    endtask

    initial begin
        clear_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random();
        if (mismatches == 0 && emit_queue.size() == 0)
            $display("topological_sort_with_cycle_break_core_test: clean");
        else
            $display("topological_sort_with_cycle_break_core_test: errors");
        $finish;
    end
endmodule
